### sv/scp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the serial command register parser: channel
// payloads, the command record passed from parser to executor, and codes.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int PARAM_COUNT  = 8;
  localparam int NUMBER_CHARS = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam int TBL_IDX_W = $clog2(PARAM_COUNT);
  localparam int CNT_W     = $clog2(NUMBER_CHARS + 1);
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ACC_W     = 17;
  localparam int PROD_W    = ACC_W + 4;
  localparam int VAL_W     = 3;
  localparam int REG_LIMIT = 7;
  localparam int REG_MAX   = (PARAM_COUNT - 1 < REG_LIMIT) ? PARAM_COUNT - 1 : REG_LIMIT;

  localparam logic [ACC_W-1:0] ACC_CAP = {ACC_W{1'b1}};
  localparam logic [15:0] TBL_ENTRY1_RESET = 16'd10;

  localparam logic [7:0] MARKER [4] = '{8'h24, 8'h43, 8'h4D, 8'h44};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_N     = 8'h4E;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SKIP1,
    PH_LETTER,
    PH_SKIP2,
    PH_REG,
    PH_VAL,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    NPH_LEAD,
    NPH_DIGITS,
    NPH_DONE
  } nphase_t;

  typedef enum logic [2:0] {
    ACT_IGNORED,
    ACT_PARAM_WRITE,
    ACT_PARAM_READ,
    ACT_REBOOT,
    ACT_SLEEP,
    ACT_ACTIVE,
    ACT_ALARM,
    ACT_NOOP
  } action_t;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_NO_COMMA,
    ERR_NO_CR,
    ERR_UNKNOWN_CTRL
  } err_t;

  typedef enum logic [VAL_W-1:0] {
    CTRL_NONE,
    CTRL_REBOOT,
    CTRL_SLEEP,
    CTRL_ACTIVE,
    CTRL_ALARM,
    CTRL_RSVD5,
    CTRL_RSVD6,
    CTRL_RSVD7
  } ctrl_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    action_t     action;
    err_t        status_code;
    logic [7:0]  command_letter;
    logic [7:0]  register_number;
    logic [15:0] reply_value;
    logic        sleep_forced;
    logic        alarm_on;
  } out_t;

  typedef struct packed {
    logic                 complete;
    err_t                 err;
    logic [7:0]           letter;
    logic [7:0]           reg_num;
    logic                 args_ok;
    logic [TBL_IDX_W-1:0] reg_idx;
    logic [VAL_W-1:0]     val;
  } cmd_rec_t;

endpackage
`default_nettype wire

### sv/serial_command_register_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_register_parser
// Parses "$CMD" messages from a byte stream and executes parameter table
// writes, reads and control actions, at most one outcome per message.
//
//   channel   ports                          payload
//   input     in_valid / in_stall / in_data  rx_byte, end_of_message
//   result    out_valid / out_stall / out_data
//                                            action, status_code, command_letter,
//                                            register_number, reply_value,
//                                            sleep_forced, alarm_on
//
// one byte accepted per cycle while in_stall is low; the parser updates phase
// and the x10 accumulate in the same cycle
// a message's record goes through the record queue, then the output register
// reset is synchronous; the parameter table comes up with entry one at 10
// out_stall holds the output register, then the two-entry record queue fills
// and raises in_stall
// ----------------------------------------------------------------------------
module serial_command_register_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire scp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output scp_pkg::out_t      out_data
);
  import scp_pkg::*;

  cmd_rec_t front_rec, q_head;
  logic     front_push, q_full, q_not_empty, q_pop, take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  scp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .push    (front_push),
    .rec     (front_rec)
  );

  scp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_rec  (front_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  scp_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_rec     (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### sv/scp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_front
// Byte parser: marker hunt, letter capture, atoi-style number accumulation,
// and at most one command record per message pushed toward the executor.
// ----------------------------------------------------------------------------
module scp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire scp_pkg::in_t      in_data,
  output logic                   push,
  output scp_pkg::cmd_rec_t      rec
);
  import scp_pkg::*;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             neg;
    nphase_t          nph;
  } num_t;

  localparam num_t NUM_CLEAR = '{acc: '0, neg: 1'b0, nph: NPH_LEAD};

  phase_t           phase_r, phase_pre, phase_nxt, src_phase;
  logic [1:0]       mm_r, mm_nxt;
  logic [7:0]       letter_r, letter_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  num_t             regn_r, regn_nxt, valn_r, valn_nxt;
  logic [7:0]       b;
  logic             eom, emit_done, emit_inc, marker_hit;

  function automatic num_t feed(input logic [7:0] ch, input num_t cur);
    num_t             res;
    logic [PROD_W-1:0] prod;
    logic             is_digit;
    res      = cur;
    is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    prod     = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1)
             + {{(PROD_W-4){1'b0}}, ch[3:0]};
    case (cur.nph)
      NPH_LEAD: begin
        if (ch inside {8'h20, [8'h09:8'h0D]}) begin
          res.nph = NPH_LEAD;
        end else if (ch == CH_PLUS) begin
          res.nph = NPH_DIGITS;
        end else if (ch == CH_MINUS) begin
          res.neg = 1'b1;
          res.nph = NPH_DIGITS;
        end else if (is_digit) begin
          res.acc = {{(ACC_W-4){1'b0}}, ch[3:0]};
          res.nph = NPH_DIGITS;
        end else begin
          res.nph = NPH_DONE;
        end
      end
      NPH_DIGITS: begin
        if (is_digit) begin
          res.acc = (prod > {4'b0, ACC_CAP}) ? ACC_CAP : prod[ACC_W-1:0];
        end else begin
          res.nph = NPH_DONE;
        end
      end
      default: res = cur;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] report(input num_t n);
    if (n.neg && n.acc != '0) return 8'd0;
    return (n.acc > ACC_W'(255)) ? 8'd255 : n.acc[7:0];
  endfunction

  function automatic logic in_range(input num_t n, input int unsigned lim);
    return (!n.neg || n.acc == '0) && (n.acc <= ACC_W'(lim));
  endfunction

  assign b          = in_data.rx_byte;
  assign eom        = in_data.end_of_message;
  assign marker_hit = (b == MARKER[mm_r]);

  // phase sequencing
  always_comb begin
    phase_pre = phase_r;
    if (phase_r == PH_DRAIN) begin
      phase_pre = PH_DRAIN;
    end else if (b == CH_NUL) begin
      phase_pre = PH_DRAIN;
    end else begin
      case (phase_r)
        PH_HUNT:   if (marker_hit && mm_r == 2'd3) phase_pre = PH_SKIP1;
        PH_SKIP1:  phase_pre = PH_LETTER;
        PH_LETTER: phase_pre = PH_SKIP2;
        PH_SKIP2:  phase_pre = PH_REG;
        PH_REG:    if (b == CH_COMMA) phase_pre = PH_VAL;
        PH_VAL:    if (b == CH_CR) phase_pre = PH_DRAIN;
        default:   phase_pre = PH_DRAIN;
      endcase
    end
    phase_nxt = eom ? PH_HUNT : phase_pre;
  end

  // datapath and record
  always_comb begin
    mm_nxt     = mm_r;
    letter_nxt = letter_r;
    cnt_nxt    = cnt_r;
    regn_nxt   = regn_r;
    valn_nxt   = valn_r;
    emit_done  = 1'b0;
    emit_inc   = 1'b0;
    src_phase  = phase_pre;
    if (phase_r != PH_DRAIN) begin
      if (b == CH_NUL) begin
        emit_inc  = (phase_r != PH_HUNT);
        src_phase = phase_r;
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (marker_hit) begin
              mm_nxt = mm_r + 2'd1;
            end else begin
              mm_nxt = (b == MARKER[0]) ? 2'd1 : 2'd0;
            end
          end
          PH_LETTER: letter_nxt = b;
          PH_SKIP2:  cnt_nxt = '0;
          PH_REG: begin
            if (b == CH_COMMA) begin
              cnt_nxt = '0;
            end else if (cnt_r < CNT_W'(NUMBER_CHARS)) begin
              cnt_nxt  = cnt_r + CNT_W'(1);
              regn_nxt = feed(b, regn_r);
            end
          end
          PH_VAL: begin
            if (b == CH_CR) begin
              emit_done = 1'b1;
            end else if (cnt_r < CNT_W'(NUMBER_CHARS)) begin
              cnt_nxt  = cnt_r + CNT_W'(1);
              valn_nxt = feed(b, valn_r);
            end
          end
          default: ;
        endcase
      end
    end
    if (eom && !emit_done && !emit_inc && phase_pre != PH_HUNT && phase_pre != PH_DRAIN) begin
      emit_inc = 1'b1;
    end

    rec.complete = emit_done;
    rec.letter   = letter_nxt;
    rec.args_ok  = in_range(regn_nxt, REG_MAX) && in_range(valn_nxt, REG_LIMIT);
    rec.reg_idx  = regn_nxt.acc[TBL_IDX_W-1:0];
    rec.val      = valn_nxt.acc[VAL_W-1:0];
    if (emit_done) begin
      rec.err     = ERR_OK;
      rec.reg_num = report(regn_nxt);
    end else if (src_phase == PH_VAL) begin
      rec.err     = ERR_NO_CR;
      rec.reg_num = report(regn_nxt);
    end else begin
      rec.err     = ERR_NO_COMMA;
      rec.reg_num = 8'd0;
    end
    push = take && (emit_done || emit_inc);

    if (eom) begin
      mm_nxt     = 2'd0;
      letter_nxt = 8'd0;
      cnt_nxt    = '0;
      regn_nxt   = NUM_CLEAR;
      valn_nxt   = NUM_CLEAR;
    end else if (phase_pre == PH_SKIP1 && phase_r == PH_HUNT) begin
      mm_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      mm_r     <= 2'd0;
      letter_r <= 8'd0;
      cnt_r    <= '0;
      regn_r   <= NUM_CLEAR;
      valn_r   <= NUM_CLEAR;
    end else if (take) begin
      phase_r  <= phase_nxt;
      mm_r     <= mm_nxt;
      letter_r <= letter_nxt;
      cnt_r    <= cnt_nxt;
      regn_r   <= regn_nxt;
      valn_r   <= valn_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/scp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_queue
// Short record queue between parser and executor so each side stalls alone.
// ----------------------------------------------------------------------------
module scp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire scp_pkg::cmd_rec_t push_rec,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output scp_pkg::cmd_rec_t      head
);
  import scp_pkg::*;

  cmd_rec_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule
`default_nettype wire

### sv/scp_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_exec
// Command executor: parameter table, sleep and alarm flags, and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module scp_exec (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire scp_pkg::cmd_rec_t q_rec,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output scp_pkg::out_t          out_data
);
  import scp_pkg::*;

  logic [15:0] tbl_r [PARAM_COUNT];
  logic        sleep_r, sleep_nxt, alarm_r, alarm_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, res;
  logic        tbl_we;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sleep_nxt           = sleep_r;
    alarm_nxt           = alarm_r;
    tbl_we              = 1'b0;
    res.action          = ACT_IGNORED;
    res.status_code     = q_rec.err;
    res.command_letter  = q_rec.letter;
    res.register_number = q_rec.reg_num;
    res.reply_value     = 16'd0;
    if (q_rec.complete && q_rec.args_ok) begin
      case (q_rec.letter)
        CH_W: begin
          if (q_rec.reg_idx == '0) begin
            case (ctrl_t'(q_rec.val))
              CTRL_REBOOT: res.action = ACT_REBOOT;
              CTRL_SLEEP: begin
                res.action = ACT_SLEEP;
                sleep_nxt  = 1'b1;
              end
              CTRL_ACTIVE: begin
                res.action = ACT_ACTIVE;
                sleep_nxt  = 1'b0;
              end
              CTRL_ALARM: begin
                res.action = ACT_ALARM;
                alarm_nxt  = 1'b1;
              end
              default: res.status_code = ERR_UNKNOWN_CTRL;
            endcase
            if (res.status_code != ERR_UNKNOWN_CTRL) begin
              res.reply_value = {{(16-VAL_W){1'b0}}, q_rec.val};
            end
          end else begin
            tbl_we          = 1'b1;
            res.action      = ACT_PARAM_WRITE;
            res.reply_value = {{(16-VAL_W){1'b0}}, q_rec.val};
          end
        end
        CH_R: begin
          res.action      = ACT_PARAM_READ;
          res.reply_value = (q_rec.reg_idx == '0) ? 16'd0 : tbl_r[q_rec.reg_idx];
        end
        CH_N:    res.action = ACT_NOOP;
        default: res.action = ACT_IGNORED;
      endcase
    end
    res.sleep_forced = sleep_nxt;
    res.alarm_on     = alarm_nxt;
    out_valid_nxt    = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sleep_r     <= 1'b0;
      alarm_r     <= 1'b0;
      for (int i = 0; i < PARAM_COUNT; i++) begin
        tbl_r[i] <= (i == 1) ? TBL_ENTRY1_RESET : 16'd0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        sleep_r <= sleep_nxt;
        alarm_r <= alarm_nxt;
        if (tbl_we) begin
          tbl_r[q_rec.reg_idx] <= {{(16-VAL_W){1'b0}}, q_rec.val};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial command register parser. A directed
// table of messages (reads of the reset table, writes, each control action,
// range and error cases, zero bytes, early buffer ends) is followed by
// random traffic that is mostly well-formed commands with random content,
// with noise and broken messages mixed in. Every accepted byte runs through
// a cycle-free parser model in the bench. Each result transfer is compared
// field by field with the oldest pending outcome (the table's for typed
// rows, else the model's). Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import scp_pkg::*;

  localparam int NUM_ROWS     = 28;
  localparam int RANDOM_BYTES = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_LIMIT = 5000;

  localparam logic [31:0] CMD_MARKER = {8'h24, 8'h43, 8'h4D, 8'h44};
  localparam logic [7:0]  CH_0     = 8'h30;
  localparam logic [7:0]  CH_9     = 8'h39;
  localparam logic [7:0]  CH_SPACE = 8'h20;

  typedef logic [7:0] text_q_t [$];

  typedef struct packed {
    in_t  data;
    logic typed;
    out_t exp;
  } stim_t;

  typedef struct {
    string text;
    int    nul_pos;
    bit    typed;
    out_t  exp;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  serial_command_register_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // parser model state
  phase_t           cur_phase;
  logic [1:0]       marker_pos;
  logic [7:0]       held_letter;
  logic [CNT_W-1:0] char_count;
  logic [16:0]      reg_acc;
  logic [16:0]      val_acc;
  logic             reg_minus;
  logic             val_minus;
  nphase_t          reg_state;
  nphase_t          val_state;
  logic [15:0]      param_mem [PARAM_COUNT];
  logic             sleep_state;
  logic             alarm_state;

  stim_t       tx_bytes [$];
  out_t        pending_outcomes [$];
  stim_t       cur_item;
  script_row_t script [NUM_ROWS];

  int   pushed = 0;
  int   accepted = 0;
  int   checked = 0;
  int   errors = 0;
  int   cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   error_hits = 0;
  int   action_hits [8];
  logic in_fire = 1'b0;
  logic calm = 1'b0;

  function automatic logic is_digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic out_t make_outcome(action_t act, err_t err, logic [7:0] reg_out,
                                        logic [15:0] reply);
    out_t o;
    o.action          = act;
    o.status_code     = err;
    o.command_letter  = held_letter;
    o.register_number = reg_out;
    o.reply_value     = reply;
    o.sleep_forced    = sleep_state;
    o.alarm_on        = alarm_state;
    return o;
  endfunction

  function automatic logic [7:0] reported_register();
    if (reg_minus && reg_acc != 0) return 8'd0;
    return (reg_acc > 255) ? 8'hFF : reg_acc[7:0];
  endfunction

  function automatic out_t partial_outcome();
    if (cur_phase == PH_VAL) return make_outcome(ACT_IGNORED, ERR_NO_CR, reported_register(), 16'd0);
    return make_outcome(ACT_IGNORED, ERR_NO_COMMA, 8'd0, 16'd0);
  endfunction

  function automatic out_t finished_outcome();
    logic [16:0] r;
    logic [16:0] v;
    logic        ok;
    action_t     act;
    err_t        err;
    logic [15:0] reply;
    r     = reg_acc;
    v     = val_acc;
    act   = ACT_IGNORED;
    err   = ERR_OK;
    reply = '0;
    ok = (!reg_minus || r == 0) && r <= REG_LIMIT && r < PARAM_COUNT
         && (!val_minus || v == 0) && v <= REG_LIMIT;
    if (ok) begin
      if (held_letter == CH_W) begin
        if (r == 0) begin
          case (ctrl_t'(v[VAL_W-1:0]))
            CTRL_REBOOT: act = ACT_REBOOT;
            CTRL_SLEEP: begin
              act = ACT_SLEEP;
              sleep_state = 1'b1;
            end
            CTRL_ACTIVE: begin
              act = ACT_ACTIVE;
              sleep_state = 1'b0;
            end
            CTRL_ALARM: begin
              act = ACT_ALARM;
              alarm_state = 1'b1;
            end
            default: err = ERR_UNKNOWN_CTRL;
          endcase
          if (err == ERR_OK) reply = v[15:0];
        end else begin
          param_mem[r[TBL_IDX_W-1:0]] = v[15:0];
          act   = ACT_PARAM_WRITE;
          reply = v[15:0];
        end
      end else if (held_letter == CH_R) begin
        act   = ACT_PARAM_READ;
        reply = (r == 0) ? 16'd0 : param_mem[r[TBL_IDX_W-1:0]];
      end else if (held_letter == CH_N) begin
        act = ACT_NOOP;
      end
    end
    return make_outcome(act, err, reported_register(), reply);
  endfunction

  // atoi-like number scan, limited to the first NUMBER_CHARS characters
  task automatic take_number_char(input logic [7:0] b, inout logic [16:0] acc,
                                  inout logic minus, inout nphase_t st);
    logic [31:0] prod;
    if (char_count >= NUMBER_CHARS) return;
    char_count++;
    case (st)
      NPH_LEAD: begin
        if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) begin
        end else if (b == CH_PLUS) begin
          st = NPH_DIGITS;
        end else if (b == CH_MINUS) begin
          minus = 1'b1;
          st    = NPH_DIGITS;
        end else if (is_digit(b)) begin
          acc = 17'(b - CH_0);
          st  = NPH_DIGITS;
        end else begin
          st = NPH_DONE;
        end
      end
      NPH_DIGITS: begin
        if (is_digit(b)) begin
          prod = acc * 10 + (b - CH_0);
          acc  = (prod > ACC_CAP) ? ACC_CAP : prod[16:0];
        end else begin
          st = NPH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic restart_parse();
    cur_phase   = PH_HUNT;
    marker_pos  = '0;
    held_letter = '0;
    char_count  = '0;
    reg_acc     = '0;
    val_acc     = '0;
    reg_minus   = 1'b0;
    val_minus   = 1'b0;
    reg_state   = NPH_LEAD;
    val_state   = NPH_LEAD;
  endtask

  task automatic reset_parser_model();
    restart_parse();
    foreach (param_mem[i]) param_mem[i] = '0;
    param_mem[1] = TBL_ENTRY1_RESET;
    sleep_state  = 1'b0;
    alarm_state  = 1'b0;
  endtask

  task automatic parse_byte(input in_t item, output logic got, output out_t res);
    logic [7:0] b;
    b   = item.rx_byte;
    got = 1'b0;
    res = '0;
    if (cur_phase == PH_DRAIN) begin
    end else if (b == CH_NUL) begin
      if (cur_phase != PH_HUNT) begin
        res = partial_outcome();
        got = 1'b1;
      end
      cur_phase = PH_DRAIN;
    end else begin
      case (cur_phase)
        PH_HUNT: begin
          if (b == CMD_MARKER[8*(3-marker_pos) +: 8]) begin
            if (marker_pos == 2'd3) begin
              marker_pos = '0;
              cur_phase  = PH_SKIP1;
            end else begin
              marker_pos++;
            end
          end else begin
            marker_pos = (b == CMD_MARKER[31:24]) ? 2'd1 : 2'd0;
          end
        end
        PH_SKIP1: cur_phase = PH_LETTER;
        PH_LETTER: begin
          held_letter = b;
          cur_phase   = PH_SKIP2;
        end
        PH_SKIP2: begin
          cur_phase  = PH_REG;
          char_count = '0;
        end
        PH_REG: begin
          if (b == CH_COMMA) begin
            cur_phase  = PH_VAL;
            char_count = '0;
          end else begin
            take_number_char(b, reg_acc, reg_minus, reg_state);
          end
        end
        PH_VAL: begin
          if (b == CH_CR) begin
            res       = finished_outcome();
            got       = 1'b1;
            cur_phase = PH_DRAIN;
          end else begin
            take_number_char(b, val_acc, val_minus, val_state);
          end
        end
        default: cur_phase = PH_DRAIN;
      endcase
    end
    if (item.end_of_message) begin
      if (!got && cur_phase != PH_HUNT && cur_phase != PH_DRAIN) begin
        res = partial_outcome();
        got = 1'b1;
      end
      restart_parse();
    end
  endtask

  function automatic string show(out_t r);
    return $sformatf("act=%0d err=%0d letter=%02h reg=%0d value=%0d sleep=%0b alarm=%0b",
                     r.action, r.status_code, r.command_letter, r.register_number,
                     r.reply_value, r.sleep_forced, r.alarm_on);
  endfunction

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_outcomes.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: %s", show(got));
    end else begin
      want = pending_outcomes.pop_front();
      checked++;
      action_hits[want.action]++;
      if (want.status_code != ERR_OK) error_hits++;
      if (got.action !== want.action || got.status_code !== want.status_code
          || got.command_letter !== want.command_letter
          || got.register_number !== want.register_number
          || got.reply_value !== want.reply_value
          || got.sleep_forced !== want.sleep_forced || got.alarm_on !== want.alarm_on) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at result %0d", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin : sample_side
    logic got;
    out_t predicted;
    cycles++;
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    if (in_fire) begin
      parse_byte(cur_item.data, got, predicted);
      if (got) pending_outcomes.push_back(cur_item.typed ? cur_item.exp : predicted);
      accepted++;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap() + 1;
      end
      // a pending transfer holds until taken
      if (!(in_valid && !in_fire)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (tx_bytes.size() > 0) begin
          cur_item = tx_bytes.pop_front();
          in_data  <= cur_item.data;
          in_valid <= 1'b1;
          gap_left = calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic eom, input logic typed,
                           input out_t exp);
    stim_t s;
    s.data.rx_byte        = b;
    s.data.end_of_message = eom;
    s.typed               = typed;
    s.exp                 = exp;
    tx_bytes.push_back(s);
    pushed++;
  endtask

  function automatic logic [7:0] pick_filler();
    return ($urandom_range(0, 2) != 0) ? CH_SPACE : 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_digit(int lo, int hi);
    return 8'(CH_0 + $urandom_range(lo, hi));
  endfunction

  task automatic add_number(ref text_q_t m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      m.push_back(pick_digit(0, 7));
    end else if (r < 63) begin
      m.push_back(pick_digit(8, 9));
    end else if (r < 71) begin
      repeat ($urandom_range(1, 3))
        m.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 12)));
      if ($urandom_range(0, 1)) m.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      m.push_back(pick_digit(0, 7));
    end else if (r < 79) begin
      repeat ($urandom_range(2, 5)) m.push_back(pick_digit(0, 9));
    end else if (r < 85) begin
      repeat ($urandom_range(8, 12)) m.push_back(pick_digit(0, 9));
    end else if (r < 90) begin
      m.push_back(CH_MINUS);
      m.push_back(pick_digit(0, 9));
    end else if (r < 94) begin
    end else if (r < 97) begin
      m.push_back(pick_digit(0, 7));
      m.push_back(8'($urandom_range(8'h41, 8'h7A)));
      m.push_back(pick_digit(0, 9));
    end else begin
      repeat ($urandom_range(1, 9)) m.push_back(CH_0);
      m.push_back(pick_digit(0, 7));
    end
  endtask

  task automatic queue_random_message();
    text_q_t msg;
    int      kind;
    int      cut;
    logic    noise;
    logic    hold_open;
    kind      = $urandom_range(0, 99);
    noise     = kind < 10;
    hold_open = $urandom_range(0, 19) == 0;
    if (noise) begin
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) msg.push_back(pick_filler());
      if ($urandom_range(0, 9) == 0) begin
        msg.push_back(CMD_MARKER[31:24]);
        msg.push_back(CMD_MARKER[23:16]);
      end
      for (int k = 3; k >= 0; k--) msg.push_back(CMD_MARKER[8*k +: 8]);
      msg.push_back(pick_filler());
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: msg.push_back(CH_W);
        8, 9, 10, 11, 12, 13:   msg.push_back(CH_R);
        14, 15, 16:             msg.push_back(CH_N);
        default:                msg.push_back(8'($urandom_range(1, 255)));
      endcase
      msg.push_back(pick_filler());
      add_number(msg);
      if ($urandom_range(0, 9) != 0) msg.push_back(CH_COMMA);
      add_number(msg);
      if ($urandom_range(0, 9) != 0) msg.push_back(CH_CR);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
      if (kind < 15) begin
        msg[$urandom_range(0, msg.size() - 1)] = CH_NUL;
      end else if (kind < 20) begin
        cut = $urandom_range(1, msg.size());
        while (msg.size() > cut) void'(msg.pop_back());
      end
    end
    foreach (msg[i])
      push_item(msg[i], noise ? ($urandom_range(0, 3) == 0 || i == msg.size() - 1)
                              : (i == msg.size() - 1 && !hold_open), 1'b0, '0);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    wait (accepted == pushed);
    while (pending_outcomes.size() > 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_outcomes.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int random_start;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    foreach (action_hits[i]) action_hits[i] = 0;
    reset_parser_model();
    script = '{
      '{"$CMD R 1,0\015", -1, 1'b1, '{ACT_PARAM_READ, ERR_OK, CH_R, 8'd1, 16'd10, 1'b0, 1'b0}},
      '{"$CMD W 1,5\015", -1, 1'b1, '{ACT_PARAM_WRITE, ERR_OK, CH_W, 8'd1, 16'd5, 1'b0, 1'b0}},
      '{"$CMD R 1,0\015", -1, 1'b1, '{ACT_PARAM_READ, ERR_OK, CH_R, 8'd1, 16'd5, 1'b0, 1'b0}},
      '{"$CMD R 0,0\015", -1, 1'b1, '{ACT_PARAM_READ, ERR_OK, CH_R, 8'd0, 16'd0, 1'b0, 1'b0}},
      '{"$CMD W 7,7\015", -1, 1'b1, '{ACT_PARAM_WRITE, ERR_OK, CH_W, 8'd7, 16'd7, 1'b0, 1'b0}},
      '{"$CMD R 7,0\015", -1, 1'b1, '{ACT_PARAM_READ, ERR_OK, CH_R, 8'd7, 16'd7, 1'b0, 1'b0}},
      '{"$CMD W 0,1\015", -1, 1'b1, '{ACT_REBOOT, ERR_OK, CH_W, 8'd0, 16'd1, 1'b0, 1'b0}},
      '{"$CMD W 0,2\015", -1, 1'b1, '{ACT_SLEEP, ERR_OK, CH_W, 8'd0, 16'd2, 1'b1, 1'b0}},
      '{"$CMD W 0,4\015", -1, 1'b1, '{ACT_ALARM, ERR_OK, CH_W, 8'd0, 16'd4, 1'b1, 1'b1}},
      '{"$CMD W 0,3\015", -1, 1'b1, '{ACT_ACTIVE, ERR_OK, CH_W, 8'd0, 16'd3, 1'b0, 1'b1}},
      '{"$CMD W 0,5\015", -1, 1'b1,
        '{ACT_IGNORED, ERR_UNKNOWN_CTRL, CH_W, 8'd0, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W 0,0\015", -1, 1'b1,
        '{ACT_IGNORED, ERR_UNKNOWN_CTRL, CH_W, 8'd0, 16'd0, 1'b0, 1'b1}},
      '{"$CMD N 3,3\015", -1, 1'b1, '{ACT_NOOP, ERR_OK, CH_N, 8'd3, 16'd0, 1'b0, 1'b1}},
      '{"$CMD X 1,1\015", -1, 1'b1, '{ACT_IGNORED, ERR_OK, 8'h58, 8'd1, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W 8,1\015", -1, 1'b1, '{ACT_IGNORED, ERR_OK, CH_W, 8'd8, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W 1,8\015", -1, 1'b1, '{ACT_IGNORED, ERR_OK, CH_W, 8'd1, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W 99999999,1\015", -1, 1'b1,
        '{ACT_IGNORED, ERR_OK, CH_W, 8'd255, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W -1,1\015", -1, 1'b1, '{ACT_IGNORED, ERR_OK, CH_W, 8'd0, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W 2", -1, 1'b1, '{ACT_IGNORED, ERR_NO_COMMA, CH_W, 8'd0, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W 2,3", -1, 1'b1, '{ACT_IGNORED, ERR_NO_CR, CH_W, 8'd2, 16'd0, 1'b0, 1'b1}},
      '{"$CMD", -1, 1'b1, '{ACT_IGNORED, ERR_NO_COMMA, 8'h00, 8'd0, 16'd0, 1'b0, 1'b1}},
      '{"$CMD W -0, +3\015", -1, 1'b0, '0},
      '{"xx$C$CMD R 1,0\015", -1, 1'b0, '0},
      '{"$CMD R 1?,0\015", 8, 1'b0, '0},
      '{"ab?cd$CMD R 1,0\015", 2, 1'b0, '0},
      '{"$CMD W 1,123456789\015", -1, 1'b0, '0},
      '{"$CMD W 3,2\015$CMD W 4,4\015", -1, 1'b0, '0},
      '{"$CMD R  +000004 ,-0\015", -1, 1'b0, '0}
    };
    foreach (script[r]) begin
      for (int i = 0; i < script[r].text.len(); i++)
        push_item((i == script[r].nul_pos) ? CH_NUL : script[r].text[i],
                  i == script[r].text.len() - 1, script[r].typed, script[r].exp);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender holds off until the directed outcomes have all drained
    settle();
    random_start = pushed;
    while (pushed - random_start < RANDOM_BYTES) queue_random_message();
    settle();

    if (pending_outcomes.size() > 0) begin
      $display("%0d expected results never arrived", pending_outcomes.size());
      errors += pending_outcomes.size();
    end
    $display("%0d bytes in %0d cycles: %0d table messages then random traffic, %0d outcomes",
             accepted, cycles, NUM_ROWS, checked);
    $display("writes %0d, reads %0d, controls %0d, no-ops %0d, ignored %0d (%0d with error)",
             action_hits[ACT_PARAM_WRITE], action_hits[ACT_PARAM_READ],
             action_hits[ACT_REBOOT] + action_hits[ACT_SLEEP] + action_hits[ACT_ACTIVE]
             + action_hits[ACT_ALARM], action_hits[ACT_NOOP], action_hits[ACT_IGNORED],
             error_hits);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
